[design/sfr_pkg.sv]
// Shared types and constants for the stream find-and-replace block.
package sfr_pkg;

    localparam int MaxPattern     = 8;
    localparam int MaxReplacement = 8;
    localparam int HoldDepth      = MaxPattern - 1;
    localparam int QueueDepth     = 2;

    typedef enum logic [1:0] {
        REG_PATTERN_BYTES      = 2'd0,
        REG_PATTERN_LENGTH     = 2'd1,
        REG_REPLACEMENT_BYTES  = 2'd2,
        REG_REPLACEMENT_LENGTH = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [63:0] pattern_bytes;
        logic [3:0]  pattern_length;
        logic [63:0] replacement_bytes;
        logic [3:0]  replacement_length;
    } t_cfg;

    // One emit command: count bytes from data, lowest byte first.
    typedef struct packed {
        logic [63:0] data;
        logic [3:0]  count;
        logic        is_end;
    } t_cmd;

    // Handshake between a producer and the command queue, and the queue and a consumer.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

[design/sfr_front.sv]
// Front end: holds candidate match bytes and turns each input word into an emit command.
module sfr_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [7:0]       i_data_byte,
    input  logic             i_end_marker,
    input  sfr_pkg::t_cfg    i_cfg,
    input  sfr_pkg::t_q_status i_q_status,
    output logic             o_full,
    output logic             o_q_push,
    output sfr_pkg::t_cmd    o_q_cmd
);

    logic [7:0] r_held [sfr_pkg::HoldDepth];
    logic [2:0] r_held_cnt;
    logic [7:0] n_held [sfr_pkg::HoldDepth];
    logic [2:0] n_held_cnt;

    logic [7:0]  cand [8];
    logic [7:0]  pat  [8];
    logic [63:0] cand_vec;
    logic [63:0] held_vec;
    logic [3:0]  cnt_in;
    logic [3:0]  plen;
    logic [3:0]  rlen;
    logic [3:0]  rem;
    logic [8:0]  ok;
    logic [3:0]  k_sel;
    logic [3:0]  rem_sel;
    logic        is_match;
    logic        accept;
    logic [7:0]  shifted [sfr_pkg::HoldDepth];

    assign o_full = i_q_status.full;
    assign accept = i_push && !i_q_status.full;

    always_comb begin
        plen = i_cfg.pattern_length;
        if (plen == 4'd0) begin
            plen = 4'd1;
        end else if (plen > 4'(sfr_pkg::MaxPattern)) begin
            plen = 4'(sfr_pkg::MaxPattern);
        end
        rlen = i_cfg.replacement_length;
        if (rlen > 4'(sfr_pkg::MaxReplacement)) begin
            rlen = 4'(sfr_pkg::MaxReplacement);
        end
    end

    // Candidate window: held bytes followed by the new byte.
    always_comb begin
        cnt_in = {1'b0, r_held_cnt} + 4'd1;
        for (int i = 0; i < sfr_pkg::HoldDepth; i++) begin
            cand[i] = (3'(i) == r_held_cnt) ? i_data_byte : r_held[i];
        end
        cand[7] = i_data_byte;
        for (int j = 0; j < 8; j++) begin
            pat[j] = i_cfg.pattern_bytes[8*j +: 8];
            cand_vec[8*j +: 8] = cand[j];
        end
        held_vec = '0;
        for (int i = 0; i < sfr_pkg::HoldDepth; i++) begin
            held_vec[8*i +: 8] = r_held[i];
        end
    end

    // For each release count k, check whether the remaining bytes stop the release.
    always_comb begin
        ok  = '0;
        rem = '0;
        for (int k = 0; k <= 8; k++) begin
            rem   = cnt_in - 4'(k);
            ok[k] = (4'(k) <= cnt_in) && (rem <= plen) && ((k == 0) || (rem < plen));
            for (int j = 0; j < 8; j++) begin
                if (k + j < 8) begin
                    if ((4'(j) < rem) && (cand[k + j] != pat[j])) begin
                        ok[k] = 1'b0;
                    end
                end
            end
        end
        k_sel = 4'd8;
        for (int k = 8; k >= 0; k--) begin
            if (ok[k]) begin
                k_sel = 4'(k);
            end
        end
        rem_sel  = cnt_in - k_sel;
        is_match = (rem_sel == plen);
    end

    // Drop the released bytes from the window.
    always_comb begin
        for (int i = 0; i < sfr_pkg::HoldDepth; i++) begin
            shifted[i] = cand[i];
        end
        for (int k = 0; k <= 8; k++) begin
            if (k_sel == 4'(k)) begin
                for (int i = 0; i < sfr_pkg::HoldDepth; i++) begin
                    if (i + k < 8) begin
                        shifted[i] = cand[i + k];
                    end
                end
            end
        end
    end

    always_comb begin
        n_held     = r_held;
        n_held_cnt = r_held_cnt;
        o_q_cmd    = '0;
        if (i_end_marker) begin
            o_q_cmd.data   = held_vec;
            o_q_cmd.count  = {1'b0, r_held_cnt};
            o_q_cmd.is_end = 1'b1;
            n_held_cnt     = '0;
        end else if (is_match) begin
            o_q_cmd.data  = i_cfg.replacement_bytes;
            o_q_cmd.count = rlen;
            n_held_cnt    = '0;
        end else begin
            o_q_cmd.data  = cand_vec;
            o_q_cmd.count = k_sel;
            n_held        = shifted;
            n_held_cnt    = rem_sel[2:0];
        end
        // Skip commands that emit nothing.
        o_q_push = accept && (o_q_cmd.count != 4'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_cnt <= '0;
        end else if (accept) begin
            r_held_cnt <= n_held_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_held <= n_held;
        end
    end

endmodule

[design/sfr_queue.sv]
// Two-entry command queue between the front end and the byte emitter.
module sfr_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  sfr_pkg::t_cmd      i_cmd,
    input  logic               i_pop,
    output sfr_pkg::t_cmd      o_cmd,
    output sfr_pkg::t_q_status o_status
);

    sfr_pkg::t_cmd r_mem [sfr_pkg::QueueDepth];
    logic          r_wr_ptr;
    logic          r_rd_ptr;
    logic [1:0]    r_count;
    logic          do_push;
    logic          do_pop;

    assign o_status.full  = (r_count == 2'(sfr_pkg::QueueDepth));
    assign o_status.empty = (r_count == 2'd0);
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_cmd          = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 2'd1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

[design/sfr_back.sv]
// Back end: outputs queued commands, one word per cycle while i_pop is high.
module sfr_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sfr_pkg::t_cmd      i_q_cmd,
    input  sfr_pkg::t_q_status i_q_status,
    output logic               o_q_pop,
    input  logic               i_pop,
    output logic               o_empty,
    output logic [7:0]         o_out_byte,
    output logic               o_run_last,
    output logic               o_stream_done
);

    logic          r_busy;
    sfr_pkg::t_cmd r_cmd;
    logic [2:0]    r_idx;
    logic          is_last;
    logic          take;
    logic          load;

    assign is_last = (r_idx == 3'(r_cmd.count - 4'd1));
    assign take    = i_pop && r_busy;
    assign load    = !r_busy || (take && is_last);
    assign o_q_pop = load && !i_q_status.empty;

    assign o_empty       = !r_busy;
    assign o_out_byte    = r_cmd.data[{r_idx, 3'b000} +: 8];
    assign o_run_last    = is_last;
    assign o_stream_done = is_last && r_cmd.is_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (load) begin
            r_busy <= !i_q_status.empty;
        end
    end

    // Load the next command or advance through the current one.
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cmd <= i_q_cmd;
            r_idx <= '0;
        end else if (take) begin
            r_idx <= r_idx + 3'd1;
        end
    end

endmodule

[design/stream_find_replace_unit.sv]
// Top level of the stream find-and-replace block with its register port.
//
// Input channel: drive i_data_byte / i_end_marker with push; a word is taken
// at a clock edge where push is high and full is low. An end-marker word
// flushes the bytes still held as a possible match start.
// Output channel: while empty is low, o_out_byte, o_run_last and
// o_stream_done show the oldest result word; pop takes it. o_run_last marks
// the last word caused by one input word, o_stream_done the last word of a
// flush. Input words that cause no result produce nothing at the output.
// Each result passes through the command queue into the emitter.
// Throughput: the emitter gives one word per cycle while pop is high and
// commands are queued; an input word that causes n results (n up to 8)
// holds the emitter until its last word is popped, and words with no
// result stay in the front end. A two-entry command queue between front
// end and emitter lets input continue while output stalls; when the
// receiver holds off pop, the queue fills and full rises.
// Reset (synchronous, active low) empties the hold buffer and queue and sets
// the registers to pattern length 1, all other fields zero.
// Registers sit at byte addresses 0, 8, 16, 24; write only while idle.
module stream_find_replace_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_marker,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_out_byte,
    output logic        o_run_last,
    output logic        o_stream_done,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    sfr_pkg::t_cfg      r_cfg;
    sfr_pkg::t_reg_idx  reg_idx;
    sfr_pkg::t_cmd      front_cmd;
    sfr_pkg::t_cmd      queue_cmd;
    sfr_pkg::t_q_status q_status;
    logic               q_push;
    logic               q_pop;
    logic               cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = sfr_pkg::t_reg_idx'(paddr[4:3]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pattern_bytes      <= '0;
            r_cfg.pattern_length     <= 4'd1;
            r_cfg.replacement_bytes  <= '0;
            r_cfg.replacement_length <= '0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                sfr_pkg::REG_PATTERN_BYTES:      r_cfg.pattern_bytes      <= pwdata;
                sfr_pkg::REG_PATTERN_LENGTH:     r_cfg.pattern_length     <= pwdata[3:0];
                sfr_pkg::REG_REPLACEMENT_BYTES:  r_cfg.replacement_bytes  <= pwdata;
                sfr_pkg::REG_REPLACEMENT_LENGTH: r_cfg.replacement_length <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            sfr_pkg::REG_PATTERN_BYTES:      prdata = r_cfg.pattern_bytes;
            sfr_pkg::REG_PATTERN_LENGTH:     prdata = {60'd0, r_cfg.pattern_length};
            sfr_pkg::REG_REPLACEMENT_BYTES:  prdata = r_cfg.replacement_bytes;
            sfr_pkg::REG_REPLACEMENT_LENGTH: prdata = {60'd0, r_cfg.replacement_length};
            default:                         prdata = '0;
        endcase
    end

    sfr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_data_byte  (i_data_byte),
        .i_end_marker (i_end_marker),
        .i_cfg        (r_cfg),
        .i_q_status   (q_status),
        .o_full       (full),
        .o_q_push     (q_push),
        .o_q_cmd      (front_cmd)
    );

    sfr_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_cmd    (front_cmd),
        .i_pop    (q_pop),
        .o_cmd    (queue_cmd),
        .o_status (q_status)
    );

    sfr_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_cmd       (queue_cmd),
        .i_q_status    (q_status),
        .o_q_pop       (q_pop),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_out_byte    (o_out_byte),
        .o_run_last    (o_run_last),
        .o_stream_done (o_stream_done)
    );

endmodule
